>>> rtl/core/rcbm_pkg.sv
// Shared types, sizes and cosine table builder for the common-band window.
package rcbm_pkg;

	localparam int MAX_BINS = 65536;
	localparam int COS_TABLE_ENTRIES = 1024;

	localparam int Q16_ONE = 65536;
	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// Largest usable FFT length: the register field is 17 bits wide
	localparam int N_MAX = (MAX_BINS < 131071) ? MAX_BINS : 131071;
	localparam int NW = $clog2(N_MAX + 1);
	// Signed bin number k, wide enough for any 16-bit index
	localparam int KW = ((NW > 16) ? NW : 16) + 1;
	// 2*k*prf and (ref+sec)*N
	localparam int P1W = KW + 32;
	localparam int P2W = 33 + NW + 1;
	// Magnitude of the offset numerator
	localparam int DW = (P1W > P2W) ? P1W : P2W;
	// Modulus 2*N*prf
	localparam int MW = NW + 32;
	// Band edges and transition denominator
	localparam int LW = 49;
	// Remainder width shared by all divider cells
	localparam int RW = (MW > LW) ? MW : LW;
	localparam int QW = 32;
	// Quotient bits of the transition ratio (one integer bit, 17 fraction bits)
	localparam int TQW = 18;

	localparam int HALF_N = COS_TABLE_ENTRIES / 2 + 1;
	localparam int HIW = $clog2(HALF_N);
	localparam int JW = $clog2(COS_TABLE_ENTRIES + 1);

	// Reset values of the registers and of their derived products
	localparam int RST_N = (4096 > N_MAX) ? N_MAX : 4096;
	localparam int RST_PRF = 256;
	localparam int RST_BETA = 16384;
	localparam longint RST_MOD = 2 * RST_N * RST_PRF;

	localparam longint unsigned TAY_DIV [1:6] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};

	typedef enum logic [1:0] {
		CFG_BANDWIDTH  = 2'd0,
		CFG_PULSE_RATE = 2'd1,
		CFG_ROLLOFF    = 2'd2,
		CFG_BINS       = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REGION_PASS  = 2'd0,
		REGION_TRANS = 2'd1,
		REGION_STOP  = 2'd2
	} region_t;

	// Per-item data that rides along the divider chains
	typedef struct packed {
		logic [31:0] shift;
		logic        err;
		region_t     region;
	} side_t;

	// Working word of one divider cell
	typedef struct packed {
		logic [RW-1:0] rem;
		logic [DW-1:0] dvd;
		logic [QW-1:0] quo;
		side_t         side;
	} cell_t;

	typedef logic [16:0] half_tab_t [HALF_N];

	// 0.5*(1+cos(pi*j/E)) in Q16 for 2*j <= E, Q30 Taylor series
	function automatic longint unsigned half_taper(longint unsigned j);
		longint unsigned a;
		longint unsigned a2;
		longint unsigned p;
		longint unsigned r;
		a = (PI_Q30 * j) / COS_TABLE_ENTRIES;
		a2 = (a * a) >> 30;
		r = Q30_ONE;
		for (int n = 6; n >= 1; n--) begin
			p = ((a2 * r) >> 30) / TAY_DIV[n];
			r = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
		end
		return (Q30_ONE + r + 64'd16384) >> 15;
	endfunction

	function automatic half_tab_t build_half_tab();
		half_tab_t t;
		for (int i = 0; i < HALF_N; i++) begin
			t[i] = 17'(half_taper(64'(i)));
		end
		return t;
	endfunction

endpackage

>>> rtl/core/rcbm_div_cell.sv
// One restoring-division cell: shifts in a dividend bit, subtracts when it fits.
module rcbm_div_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [rcbm_pkg::RW-1:0]    divisor,
	input  logic                       in_vld,
	input  rcbm_pkg::cell_t            in_data,
	output logic                       out_vld,
	output rcbm_pkg::cell_t            out_data
);
	import rcbm_pkg::*;

	logic [RW:0] trial;
	logic        take;

	// Bring down the next dividend bit and test the divisor
	assign trial = {in_data.rem, in_data.dvd[DW-1]};
	assign take = (trial >= {1'b0, divisor});

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	// Advance the working word to the neighbor
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.rem <= take ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
			out_data.dvd <= in_data.dvd << 1;
			out_data.quo <= {in_data.quo[QW-2:0], take};
			out_data.side <= in_data.side;
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(out_vld) && $stable(out_data))
		else $error("divider cell changed while held");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_vld && (in_data.rem < divisor)) |=> (out_data.rem < $past(divisor)))
		else $error("partial remainder not below divisor");
	a_vld: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_vld == $past(in_vld)))
		else $error("valid flag lost in divider cell");
`endif

endmodule

>>> rtl/core/rcbm_cos_rom.sv
// Half-period raised-cosine table with registered read.
module rcbm_cos_rom (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rcbm_pkg::HIW-1:0]   addr,
	output logic [16:0]                data_q
);
	import rcbm_pkg::*;

	localparam half_tab_t TAB = build_half_tab();

	// Read one entry
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= TAB[addr];
		end
	end

endmodule

>>> rtl/core/raised_cosine_common_band_mask.sv
// Top level: raised-cosine common-band azimuth window, one coefficient per item.
//
//  channel  | handshake                  | beat
//  ---------+----------------------------+-----------------------------------------------
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//  item     | item_valid / item_stall    | ref_doppler, sec_doppler, bin_index
//  result   | result_valid / result_stall| coefficient, region, shift_error, doppler_shift
//
// One item enters every cycle while no result is held. Each item passes the input
// stages, the three chains of divider cells (offset modulo 2*N*prf, division by 2*N,
// and the transition ratio), the table stages and the output register. arst_n clears
// all valid flags and loads the register reset values. cfg_ready is always high.
// A held result freezes the whole pipeline, and item_stall rises with it. The user
// writes registers only while the pipeline is empty; the block does not enforce it.
module raised_cosine_common_band_mask (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] ref_doppler,
	input  logic signed [31:0] sec_doppler,
	input  logic [15:0]        bin_index,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [16:0]        coefficient,
	output logic [1:0]         region,
	output logic               shift_error,
	output logic [31:0]        doppler_shift
);
	import rcbm_pkg::*;

	// Registers, stored already clamped
	logic [30:0]   bw_q;
	logic [30:0]   prf_q;
	logic [16:0]   beta_q;
	logic [NW-1:0] n_q;
	logic [16:0]   cfg_n;

	// Products derived from the registers
	logic [NW:0]   two_n_q;
	logic [MW-1:0] mod_q;
	logic [LW-1:0] lo_q;
	logic [LW-1:0] hi_q;
	logic [LW-1:0] den_q;
	logic [17:0]   lo_f;
	logic [17:0]   hi_f;
	logic [LW-1:0] den_d;

	logic adv;

	// Stage 1
	logic signed [32:0]   diff_d;
	logic [32:0]          mag_d;
	logic signed [32:0]   sum_d;
	logic [NW:0]          half_d;
	logic                 low_bin;
	logic signed [KW-1:0] k_d;
	logic                 vld_s1;
	logic signed [32:0]   sum_s1;
	logic signed [KW-1:0] k_s1;
	side_t                side_s1;

	// Stage 2
	logic                  vld_s2;
	logic signed [P1W-1:0] p1_s2;
	logic signed [P2W-1:0] p2_s2;
	side_t                 side_s2;

	// Stage 3
	logic signed [DW:0] dd;
	logic [DW:0]        dmag;
	logic               vld_s3;
	logic [DW-1:0]      d_s3;
	side_t              side_s3;

	// Divider chains
	logic [DW:0]  a_vld;
	cell_t        a_dat [DW+1];
	logic [RW:0]  b_vld;
	cell_t        b_dat [RW+1];
	logic [TQW:0] c_vld;
	cell_t        c_dat [TQW+1];

	// Stage 4
	logic [LW-1:0] scaled;
	region_t       reg_d;
	logic          vld_s4;
	logic [LW-1:0] num_s4;
	side_t         side_s4;

	// Stage 5 and 6
	logic [TQW+JW:0] jx;
	logic [TQW+JW:0] jc;
	logic [JW:0]     j_d;
	logic            vld_s5;
	logic            flip_s5;
	logic [HIW-1:0]  addr_s5;
	side_t           side_s5;
	logic            vld_s6;
	logic            flip_s6;
	side_t           side_s6;
	logic [16:0]     rom_s6;

	// Output register
	logic        result_valid_q;
	logic [16:0] coef_q;
	region_t     region_q;
	logic        err_q;
	logic [31:0] shift_q;
	logic [16:0] coef_d;

	assign cfg_ready = 1'b1;
	assign cfg_n = {1'b0, cfg_data[15:0]} | {cfg_data[16], 16'd0};

	// Write a register, clamping to its usable range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= '0;
			prf_q <= 31'(RST_PRF);
			beta_q <= 17'(RST_BETA);
			n_q <= NW'(RST_N);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BANDWIDTH: begin
					bw_q <= cfg_data;
				end
				CFG_PULSE_RATE: begin
					prf_q <= (cfg_data == '0) ? 31'd1 : cfg_data;
				end
				CFG_ROLLOFF: begin
					beta_q <= (cfg_data[16:0] > 17'(Q16_ONE)) ? 17'(Q16_ONE) : cfg_data[16:0];
				end
				CFG_BINS: begin
					if (cfg_n == '0) begin
						n_q <= NW'(1);
					end else if ({15'd0, cfg_n} > 32'(N_MAX)) begin
						n_q <= NW'(N_MAX);
					end else begin
						n_q <= NW'(cfg_n);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Refresh the band edges, modulus and divisors
	assign lo_f = 18'(Q16_ONE) - {1'b0, beta_q};
	assign hi_f = 18'(Q16_ONE) + {1'b0, beta_q};
	assign den_d = LW'(bw_q) * LW'({beta_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_n_q <= (NW+1)'(2 * RST_N);
			mod_q <= MW'(RST_MOD);
			lo_q <= '0;
			hi_q <= '0;
			den_q <= LW'(1);
		end else begin
			two_n_q <= {n_q, 1'b0};
			mod_q <= MW'({n_q, 1'b0}) * MW'(prf_q);
			lo_q <= LW'(bw_q) * LW'(lo_f);
			hi_q <= LW'(bw_q) * LW'(hi_f);
			den_q <= (den_d == '0) ? LW'(1) : den_d;
		end
	end

	// Move the whole pipeline unless a finished result is held
	assign adv = !result_valid_q || !result_stall;
	assign item_stall = !adv;

	// Stage 1: shift, error flag, Doppler sum and signed bin number
	assign diff_d = 33'(ref_doppler) - 33'(sec_doppler);
	assign mag_d = diff_d[32] ? 33'(-diff_d) : 33'(diff_d);
	assign sum_d = 33'(ref_doppler) + 33'(sec_doppler);
	assign half_d = ((NW+1)'(n_q) + (NW+1)'(1)) >> 1;
	assign low_bin = (KW'(bin_index) < KW'(half_d));
	assign k_d = $signed(KW'(bin_index)) - (low_bin ? KW'(0) : $signed(KW'(n_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 2: the two products; stage 3: magnitude of their difference
	assign dd = (DW+1)'(p1_s2) - (DW+1)'(p2_s2);
	assign dmag = dd[DW] ? (DW+1)'(-dd) : (DW+1)'(dd);

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= sum_d;
			k_s1 <= k_d;
			side_s1.shift <= mag_d[31:0];
			side_s1.err <= (mag_d[31:0] > {1'b0, bw_q});
			side_s1.region <= REGION_STOP;
			p1_s2 <= (P1W'(k_s1) * $signed(P1W'(prf_q))) <<< 1;
			p2_s2 <= P2W'(sum_s1) * $signed(P2W'(n_q));
			side_s2 <= side_s1;
			d_s3 <= dmag[DW-1:0];
			side_s3 <= side_s2;
		end
	end

	// Chain A: offset modulo 2*N*prf
	assign a_vld[0] = vld_s3;
	assign a_dat[0] = '{rem: '0, dvd: d_s3, quo: '0, side: side_s3};

	for (genvar i = 0; i < DW; i++) begin : g_mod
		rcbm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.divisor  (RW'(mod_q)),
			.in_vld   (a_vld[i]),
			.in_data  (a_dat[i]),
			.out_vld  (a_vld[i+1]),
			.out_data (a_dat[i+1])
		);
	end

	// Chain B: reduced offset divided by 2*N
	assign b_vld[0] = a_vld[DW];
	assign b_dat[0] = '{rem: '0, dvd: DW'(a_dat[DW].rem) << (DW - RW), quo: '0,
		side: a_dat[DW].side};

	for (genvar i = 0; i < RW; i++) begin : g_bin
		rcbm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.divisor  (RW'(two_n_q)),
			.in_vld   (b_vld[i]),
			.in_data  (b_dat[i]),
			.out_vld  (b_vld[i+1]),
			.out_data (b_dat[i+1])
		);
	end

	// Stage 4: classify the offset against the band edges
	assign scaled = LW'(b_dat[RW].quo[30:0]) << 17;

	always_comb begin
		if (scaled <= lo_q) begin
			reg_d = REGION_PASS;
		end else if (scaled <= hi_q) begin
			reg_d = REGION_TRANS;
		end else begin
			reg_d = REGION_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= b_vld[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4 <= scaled - lo_q;
			side_s4.shift <= b_dat[RW].side.shift;
			side_s4.err <= b_dat[RW].side.err;
			side_s4.region <= reg_d;
		end
	end

	// Chain C: position within the transition band, 17 fraction bits
	assign c_vld[0] = vld_s4;
	assign c_dat[0] = '{rem: RW'(num_s4 >> 1), dvd: DW'(num_s4[0]) << (DW - 1), quo: '0,
		side: side_s4};

	for (genvar i = 0; i < TQW; i++) begin : g_frac
		rcbm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.divisor  (RW'(den_q)),
			.in_vld   (c_vld[i]),
			.in_data  (c_dat[i]),
			.out_vld  (c_vld[i+1]),
			.out_data (c_dat[i+1])
		);
	end

	// Stage 5: round to a table index and fold onto the half period
	assign jx = ((TQW+JW+1)'(c_dat[TQW].quo[TQW-1:0]) * (TQW+JW+1)'(COS_TABLE_ENTRIES)
		+ (TQW+JW+1)'(Q16_ONE)) >> 17;
	assign jc = (jx > (TQW+JW+1)'(COS_TABLE_ENTRIES)) ? (TQW+JW+1)'(COS_TABLE_ENTRIES) : jx;
	assign j_d = (JW+1)'(jc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s5 <= c_vld[TQW];
			vld_s6 <= vld_s5;
			result_valid_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flip_s5 <= ({j_d, 1'b0} > (JW+2)'(COS_TABLE_ENTRIES));
			addr_s5 <= ({j_d, 1'b0} > (JW+2)'(COS_TABLE_ENTRIES)) ?
				HIW'((JW+1)'(COS_TABLE_ENTRIES) - j_d) : HIW'(j_d);
			side_s5 <= c_dat[TQW].side;
			flip_s6 <= flip_s5;
			side_s6 <= side_s5;
		end
	end

	// Stage 6: table read
	rcbm_cos_rom u_rom (
		.clk    (clk),
		.en     (adv),
		.addr   (addr_s5),
		.data_q (rom_s6)
	);

	// Pick the coefficient by band; a shift error forces zero
	always_comb begin
		case (side_s6.region)
			REGION_PASS:  coef_d = 17'(Q16_ONE);
			REGION_TRANS: coef_d = flip_s6 ? 17'(Q16_ONE) - rom_s6 : rom_s6;
			default:      coef_d = '0;
		endcase
		if (side_s6.err) begin
			coef_d = '0;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk) begin
		if (adv) begin
			coef_q <= coef_d;
			region_q <= side_s6.region;
			err_q <= side_s6.err;
			shift_q <= side_s6.shift;
		end
	end

	assign result_valid = result_valid_q;
	assign coefficient = coef_q;
	assign region = region_q;
	assign shift_error = err_q;
	assign doppler_shift = shift_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && shift_error) |-> (coefficient == '0))
		else $error("coefficient not zero on shift error");
	a_band: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !shift_error) |->
		((region_q == REGION_PASS && coefficient == 17'(Q16_ONE)) ||
		(region_q == REGION_STOP && coefficient == '0) || (region_q == REGION_TRANS)))
		else $error("coefficient does not match its band");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(prf_q != '0) && (n_q != '0) && (beta_q <= 17'(Q16_ONE)) && (den_q != '0))
		else $error("register left outside its usable range");
`endif

endmodule

>>> tb/sv/raised_cosine_common_band_mask_tb.sv
// Self-checking testbench for the raised-cosine common-band window block.
`timescale 1ns / 1ps

module raised_cosine_common_band_mask_tb;
	import rcbm_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 175;

	typedef struct {
		logic [16:0] coef;
		region_t     rgn;
		logic        err;
		logic [31:0] shift;
	} window_beat_t;

	// Predicts one window beat per input and checks beats in order
	class window_board;
		longint unsigned bw, prf, beta, nbins;
		window_beat_t pending[$];
		int errors;

		function new();
			bw = 0;
			prf = 256;
			beta = 16384;
			nbins = 4096;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [30:0] val);
			case (idx)
				CFG_BANDWIDTH:  bw = val;
				CFG_PULSE_RATE: prf = val;
				CFG_ROLLOFF:    beta = val[16:0];
				CFG_BINS:       nbins = val[16:0];
				default:        ;
			endcase
		endfunction

		// 0.5*(1+cos(pi*j/E)) in Q16, Q30 series, first half of the table
		function longint unsigned cos_half(longint unsigned j);
			longint unsigned a, a2, p;
			longint r;
			a = (PI_Q30 * j) / COS_TABLE_ENTRIES;
			a2 = (a * a) >> 30;
			r = Q30_ONE;
			for (int n = 6; n >= 1; n--) begin
				p = (a2 * longint'(r)) >> 30;
				r = longint'(Q30_ONE) - longint'(p) / ((2 * n) * (2 * n - 1));
				if (r < 0)
					r = 0;
			end
			return (Q30_ONE + longint'(r) + 16384) >> 15;
		endfunction

		function longint unsigned cos_taper(longint unsigned j);
			if (j > COS_TABLE_ENTRIES)
				j = COS_TABLE_ENTRIES;
			if (2 * j <= COS_TABLE_ENTRIES)
				return cos_half(j);
			return Q16_ONE - cos_half(COS_TABLE_ENTRIES - j);
		endfunction

		function void note(logic signed [31:0] rd, logic signed [31:0] sd, logic [15:0] bi);
			window_beat_t w;
			longint r, s, i, n, p, k, diff, d, off;
			longint unsigned b, sc, lo, hi, num, den, tq, rem;
			r = rd;
			s = sd;
			i = bi;
			n = nbins;
			p = (prf == 0) ? 1 : prf;
			b = (beta > Q16_ONE) ? Q16_ONE : beta;
			if (n < 1)
				n = 1;
			if (n > MAX_BINS)
				n = MAX_BINS;
			diff = r - s;
			w.shift = 32'((diff < 0) ? -diff : diff);
			w.err = ((diff < 0) ? -diff : diff) > longint'(bw);
			k = (i < (n + 1) / 2) ? i : i - n;
			d = 2 * k * p - (r + s) * n;
			if (d < 0)
				d = -d;
			d = d % (2 * n * p);
			off = d / (2 * n);
			sc = longint'(off) << 17;
			lo = bw * (Q16_ONE - b);
			hi = bw * (Q16_ONE + b);
			w.coef = 0;
			if (sc <= lo) begin
				w.rgn = REGION_PASS;
				w.coef = 17'(Q16_ONE);
			end else if (sc <= hi) begin
				w.rgn = REGION_TRANS;
				num = sc - lo;
				den = 2 * bw * b;
				if (den == 0)
					den = 1;
				tq = 0;
				rem = num;
				if (rem >= den) begin
					tq = 1;
					rem -= den;
				end
				for (int q = 0; q < 17; q++) begin
					rem <<= 1;
					tq <<= 1;
					if (rem >= den) begin
						tq |= 1;
						rem -= den;
					end
				end
				w.coef = 17'(cos_taper((tq * COS_TABLE_ENTRIES + 65536) >> 17));
			end else begin
				w.rgn = REGION_STOP;
			end
			if (w.err)
				w.coef = 0;
			pending.push_back(w);
		endfunction

		function void check(window_beat_t got);
			window_beat_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat coef %0d region %0d", $time, got.coef, got.rgn);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.coef !== w.coef) begin
				$display("%0t: coefficient exp %0d got %0d", $time, w.coef, got.coef);
				errors++;
			end
			if (got.rgn !== w.rgn) begin
				$display("%0t: region exp %0d got %0d", $time, w.rgn, got.rgn);
				errors++;
			end
			if (got.err !== w.err) begin
				$display("%0t: shift_error exp %0d got %0d", $time, w.err, got.err);
				errors++;
			end
			if (got.shift !== w.shift) begin
				$display("%0t: doppler_shift exp %0d got %0d", $time, w.shift, got.shift);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;
	logic item_valid;
	logic item_stall;
	logic signed [31:0] ref_doppler;
	logic signed [31:0] sec_doppler;
	logic [15:0] bin_index;
	logic result_valid;
	logic result_stall;
	logic [16:0] coefficient;
	logic [1:0] region;
	logic shift_error;
	logic [31:0] doppler_shift;

	window_board board = new();
	int cycles = 0;
	int stall_mode = 0;

	raised_cosine_common_band_mask dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.ref_doppler(ref_doppler),
		.sec_doppler(sec_doppler),
		.bin_index(bin_index),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.coefficient(coefficient),
		.region(region),
		.shift_error(shift_error),
		.doppler_shift(doppler_shift)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** raised_cosine_common_band_mask: FAILED **");
			$finish;
		end
	end

	// Stall the result side, switching at random among four stall patterns
	always @(posedge clk) begin
		if (cycles % 300 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 1) == 0);
			default: result_stall <= ((cycles % 16) < 11);
		endcase
	end

	// Check each accepted result beat
	always @(posedge clk) begin
		window_beat_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.coef = coefficient;
			got.rgn = region_t'(region);
			got.err = shift_error;
			got.shift = doppler_shift;
			board.check(got);
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic setup(logic [30:0] bw, logic [30:0] prf, logic [16:0] b, logic [16:0] n);
		drain();
		write_reg(CFG_BANDWIDTH, bw);
		write_reg(CFG_PULSE_RATE, prf);
		write_reg(CFG_ROLLOFF, {14'd0, b});
		write_reg(CFG_BINS, {14'd0, n});
	endtask

	task automatic send_item(logic [31:0] rd, logic [31:0] sd, logic [15:0] bi);
		item_valid <= 1'b1;
		ref_doppler <= rd;
		sec_doppler <= sd;
		bin_index <= bi;
		do @(posedge clk); while (item_stall);
		board.note(rd, sd, bi);
	endtask

	// Random beat: mostly Dopplers close enough to pass the shift check
	task automatic send_random();
		logic [31:0] rd, dlt;
		logic [15:0] bi;
		longint unsigned span, nb;
		span = (board.prf == 0) ? 4 : board.prf * 4;
		if (span > 32'h7fffffff)
			span = 32'h7fffffff;
		rd = ($urandom_range(0, 3) == 0) ? $urandom()
			: 32'($urandom_range(0, 32'(span))) - 32'(span / 2);
		dlt = (board.bw > 32'hffff_fffe) ? $urandom() : $urandom_range(0, 32'(board.bw));
		if ($urandom_range(0, 5) == 0)
			dlt = $urandom();
		nb = (board.nbins == 0) ? 1 : (board.nbins > 65536 ? 65536 : board.nbins);
		bi = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32'(nb - 1)));
		send_item(rd, $urandom_range(0, 1) ? rd - dlt : rd + dlt, bi);
	endtask

	initial begin
		int gap, burst;
		logic [30:0] prf, bw;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BANDWIDTH;
		cfg_data = '0;
		item_valid = 1'b0;
		ref_doppler = '0;
		sec_doppler = '0;
		bin_index = '0;
		result_stall = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sweep bins of a small FFT, then field extremes
		setup(31'd2560, 31'd25600, 17'd16384, 17'd16);
		for (int i = 0; i < 16; i++)
			send_item(32'd0, 32'd0, 16'(i));
		send_item(32'd256, 32'd0, 16'd3);
		send_item(32'h7fffffff, 32'h80000000, 16'hffff);
		send_item(32'h80000000, 32'h80000000, 16'd8);
		send_item(32'h7fffffff, 32'h7fffffff, 16'd15);
		send_item(32'hffffffff, 32'd0, 16'd16);
		item_valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			prf = $urandom_range(1, 1 << 20);
			bw = $urandom_range(0, prf);
			case (ph)
				// zero bandwidth, rate, rolloff and length
				0: setup(31'd0, 31'd0, 17'd0, 17'd0);
				// all at their largest
				1: setup(31'h7fffffff, 31'h7fffffff, 17'd65536, 17'd65536);
				// rolloff and length beyond their range
				2: setup(bw, prf, 17'h1ffff, 17'h1ffff);
				3: setup(bw, prf, 17'($urandom_range(0, 65536)), 17'd1);
				4: setup(bw, prf, 17'($urandom_range(0, 65536)), 17'd2);
				5: setup(bw, prf, 17'd65536, 17'($urandom_range(1, 64)));
				default: setup(bw, prf, 17'($urandom_range(1, 65536)),
					17'($urandom_range(1, 4096)));
			endcase
			for (int n = 0; n < PHASE_ITEMS; ) begin
				burst = $urandom_range(1, 30);
				for (int b = 0; b < burst && n < PHASE_ITEMS; b++, n++)
					send_random();
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					item_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				// in phase 4, hold off mid phase until the pipeline empties
				if (ph == 4 && n >= PHASE_ITEMS / 2 && n < PHASE_ITEMS / 2 + 30) begin
					item_valid <= 1'b0;
					drain();
				end
			end
			item_valid <= 1'b0;
		end

		drain();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("** raised_cosine_common_band_mask: PASSED **");
		else
			$display("** raised_cosine_common_band_mask: FAILED **");
		$finish;
	end

endmodule
